### rtl/aru_pkg.sv
package aru_pkg;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_ADC  = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_SBB  = 5'd3;
   localparam logic [4:0] OP_CMP  = 5'd4;
   localparam logic [4:0] OP_INC  = 5'd5;
   localparam logic [4:0] OP_DEC  = 5'd6;
   localparam logic [4:0] OP_NEG  = 5'd7;
   localparam logic [4:0] OP_AAA  = 5'd8;
   localparam logic [4:0] OP_DAA  = 5'd9;
   localparam logic [4:0] OP_AAS  = 5'd10;
   localparam logic [4:0] OP_DAS  = 5'd11;
   localparam logic [4:0] OP_MUL  = 5'd12;
   localparam logic [4:0] OP_IMUL = 5'd13;
   localparam logic [4:0] OP_DIV  = 5'd14;
   localparam logic [4:0] OP_IDIV = 5'd15;
   localparam logic [4:0] OP_AAD  = 5'd16;
   localparam logic [4:0] OP_CBW  = 5'd17;
   localparam logic [4:0] OP_CWD  = 5'd18;

   // Sixteen restoring division steps, spread evenly over the divider stages.
   localparam int DIV_STAGES     = 8;
   localparam int BITS_PER_STAGE = 2;

   typedef struct packed {
      logic [4:0]  opcode;
      logic        word_size;
      logic [15:0] dest;
      logic [15:0] src;
      logic [15:0] ax;
      logic [15:0] dx;
      logic        cin;
      logic        ain;
   } req_type;

   typedef struct packed {
      logic [15:0] res;
      logic        wb;
      logic [15:0] ax;
      logic [15:0] dx;
      logic        cf;
      logic        pf;
      logic        af;
      logic        zf;
      logic        sf;
      logic        of;
   } rec_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [15:0] quo;
      logic [15:0] dvsr;
      logic        nd;
      logic        nv;
      logic        err;
   } div_type;

   typedef struct packed {
      logic [4:0]  opcode;
      logic        word_size;
      rec_type     rec;
      logic [31:0] prod;
      div_type     dv;
   } pipe_type;

   function automatic logic parity(input logic [7:0] v);
      return ~^v;
   endfunction

endpackage

### rtl/x86_16bit_arithmetic_unit.sv
// 8086 arithmetic unit: ADD..NEG, decimal adjusts, MUL/IMUL, DIV/IDIV, AAD,
// CBW and CWD on byte or word operands.
// Requests arrive on the req_ channel (valid/stall) with the opcode, size,
// operands, AX, DX and the incoming CF and AF. Each request gives exactly one
// response on the rsp_ channel with the destination result, write-back mark,
// new AX and DX, the six flags and a divide-error mark.
// The unit is a pipeline of eleven register stages: input capture, operand
// stage (adder, BCD adjust, 17x17 multiplier, divider setup), eight divider
// stages retiring two quotient bits each, and the output register. A new
// request can be accepted every cycle unless the pipeline is frozen by a
// stalled response.
// While rsp_stall holds a valid response, the whole pipeline freezes and
// req_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline comes up empty and accepts a
// request as soon as reset is released.
module x86_16bit_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_opcode,
   input  logic        req_word_size,
   input  logic [15:0] req_dest_value,
   input  logic [15:0] req_src_value,
   input  logic [15:0] req_acc_low_word,
   input  logic [15:0] req_acc_high_word,
   input  logic        req_carry_in,
   input  logic        req_aux_carry_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_value,
   output logic        rsp_write_back,
   output logic [15:0] rsp_acc_low_out,
   output logic [15:0] rsp_acc_high_out,
   output logic        rsp_carry_out,
   output logic        rsp_parity_out,
   output logic        rsp_aux_carry_out,
   output logic        rsp_zero_out,
   output logic        rsp_sign_out,
   output logic        rsp_overflow_out,
   output logic        rsp_divide_error
);

   localparam int NSTG = aru_pkg::DIV_STAGES;

   logic                      adv;
   logic                      in_valid_ff;
   aru_pkg::req_type          in_ff;
   logic [NSTG:0]             pipe_valid_ff;
   aru_pkg::pipe_type         pipe_ff [0:NSTG];
   aru_pkg::pipe_type         pipe_in [0:NSTG];
   aru_pkg::rec_type          back_rec;
   logic                      back_err;
   logic                      out_valid_ff;
   aru_pkg::rec_type          out_ff;
   logic                      out_err_ff;
   logic [4:0]                out_op_ff;

   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;

   aru_front u_front (
      .req  (in_ff),
      .pipe (pipe_in[0])
   );

   for (genvar g = 0; g < NSTG; g++) begin : g_div
      aru_div_stage u_stage (
         .stage_in  (pipe_ff[g]),
         .stage_out (pipe_in[g+1])
      );
   end

   aru_back u_back (
      .pipe    (pipe_ff[NSTG]),
      .rec     (back_rec),
      .div_err (back_err)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pipe_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else if (adv) begin
         in_valid_ff   <= req_valid;
         pipe_valid_ff <= {pipe_valid_ff[NSTG-1:0], in_valid_ff};
         out_valid_ff  <= pipe_valid_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff.opcode    <= req_opcode;
         in_ff.word_size <= req_word_size;
         in_ff.dest      <= req_dest_value;
         in_ff.src       <= req_src_value;
         in_ff.ax        <= req_acc_low_word;
         in_ff.dx        <= req_acc_high_word;
         in_ff.cin       <= req_carry_in;
         in_ff.ain       <= req_aux_carry_in;
         for (int i = 0; i <= NSTG; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
         out_ff     <= back_rec;
         out_err_ff <= back_err;
         out_op_ff  <= pipe_ff[NSTG].opcode;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_value  = out_ff.res;
   assign rsp_write_back    = out_ff.wb;
   assign rsp_acc_low_out   = out_ff.ax;
   assign rsp_acc_high_out  = out_ff.dx;
   assign rsp_carry_out     = out_ff.cf;
   assign rsp_parity_out    = out_ff.pf;
   assign rsp_aux_carry_out = out_ff.af;
   assign rsp_zero_out      = out_ff.zf;
   assign rsp_sign_out      = out_ff.sf;
   assign rsp_overflow_out  = out_ff.of;
   assign rsp_divide_error  = out_err_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> out_valid_ff)
      else $error("request stalled with no response held");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> ($stable(pipe_valid_ff) && $stable(in_valid_ff)))
      else $error("pipeline moved while the response was stalled");

   a_div_error_op: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_err_ff) |->
         (out_op_ff == aru_pkg::OP_DIV || out_op_ff == aru_pkg::OP_IDIV))
      else $error("divide error on a non-divide operation");

   a_mul_flags: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_op_ff == aru_pkg::OP_MUL || out_op_ff == aru_pkg::OP_IMUL))
         |-> (out_ff.cf == out_ff.of))
      else $error("multiply carry and overflow disagree");
`endif

endmodule

### rtl/aru_front.sv
module aru_front (
   input  aru_pkg::req_type  req,
   output aru_pkg::pipe_type pipe
);

   logic [15:0] mask, sign, d, s, x, y, ar;
   logic        cy, sub, keep;
   logic [16:0] sum17;
   logic        acf, aof, aaf;
   logic [7:0]  al, ah, al1, al2, aln;
   logic        cond, big;
   logic [15:0] tax;
   logic        sgn, nd, nv;
   logic [31:0] dividend, negd, a;
   logic [16:0] bneg;
   logic [15:0] b, hi;
   logic [16:0] ma, mb;
   logic [33:0] prod34;
   logic [31:0] mprod;
   aru_pkg::div_type dvs;

   always_comb begin
      mask = req.word_size ? 16'hFFFF : 16'h00FF;
      sign = req.word_size ? 16'h8000 : 16'h0080;
      d    = req.dest & mask;
      s    = req.src & mask;
      x    = d;
      y    = s;
      cy   = 1'b0;
      sub  = 1'b0;
      keep = 1'b0;
      unique case (req.opcode)
         aru_pkg::OP_ADC: cy = req.cin;
         aru_pkg::OP_SUB, aru_pkg::OP_CMP: sub = 1'b1;
         aru_pkg::OP_SBB: begin
            sub = 1'b1;
            cy  = req.cin;
         end
         aru_pkg::OP_INC: begin
            y    = 16'h0001;
            keep = 1'b1;
         end
         aru_pkg::OP_DEC: begin
            y    = 16'h0001;
            sub  = 1'b1;
            keep = 1'b1;
         end
         aru_pkg::OP_NEG: begin
            x   = 16'h0000;
            y   = d;
            sub = 1'b1;
         end
         default: ;
      endcase
      sum17 = sub ? ({1'b0, x} - {1'b0, y} - {16'h0000, cy})
                  : ({1'b0, x} + {1'b0, y} + {16'h0000, cy});
      ar  = sum17[15:0] & mask;
      acf = sub ? sum17[16] : (req.word_size ? sum17[16] : sum17[8]);
      aof = sub ? |((x ^ y) & (x ^ ar) & sign) : |((x ^ ar) & (y ^ ar) & sign);
      aaf = x[4] ^ y[4] ^ ar[4];
   end

   always_comb begin
      al   = req.ax[7:0];
      ah   = req.ax[15:8];
      cond = (al[3:0] > 4'd9) || req.ain;
      big  = (al > 8'h99) || req.cin;
      tax  = (req.opcode == aru_pkg::OP_AAA) ? (req.ax + 16'h0106) : (req.ax - 16'h0106);
      if (req.opcode == aru_pkg::OP_DAA) begin
         al1 = cond ? (al + 8'h06) : al;
         al2 = big ? (al1 + 8'h60) : al1;
      end else begin
         al1 = cond ? (al - 8'h06) : al;
         al2 = big ? (al1 - 8'h60) : al1;
      end
      aln = al + {ah[4:0], 3'b000} + {ah[6:0], 1'b0};

      pipe.opcode    = req.opcode;
      pipe.word_size = req.word_size;
      pipe.prod      = mprod;
      pipe.dv        = dvs;
      pipe.rec       = '0;
      pipe.rec.ax    = req.ax;
      pipe.rec.dx    = req.dx;
      unique case (req.opcode)
         aru_pkg::OP_ADD, aru_pkg::OP_ADC, aru_pkg::OP_SUB, aru_pkg::OP_SBB,
         aru_pkg::OP_CMP, aru_pkg::OP_INC, aru_pkg::OP_DEC, aru_pkg::OP_NEG: begin
            pipe.rec.cf = keep ? req.cin : acf;
            pipe.rec.af = aaf;
            pipe.rec.of = aof;
            pipe.rec.zf = (ar == 16'h0000);
            pipe.rec.sf = |(ar & sign);
            pipe.rec.pf = aru_pkg::parity(ar[7:0]);
         end
         aru_pkg::OP_AAA, aru_pkg::OP_AAS: begin
            pipe.rec.ax = (cond ? tax : req.ax) & 16'hFF0F;
            pipe.rec.cf = cond;
            pipe.rec.af = cond;
            pipe.rec.zf = (pipe.rec.ax[7:0] == 8'h00);
            pipe.rec.sf = pipe.rec.ax[7];
            pipe.rec.pf = aru_pkg::parity(pipe.rec.ax[7:0]);
         end
         aru_pkg::OP_DAA, aru_pkg::OP_DAS: begin
            pipe.rec.ax = {ah, al2};
            pipe.rec.cf = big;
            pipe.rec.af = cond;
            pipe.rec.zf = (al2 == 8'h00);
            pipe.rec.sf = al2[7];
            pipe.rec.pf = aru_pkg::parity(al2);
         end
         aru_pkg::OP_AAD: begin
            pipe.rec.ax = {8'h00, aln};
            pipe.rec.zf = (aln == 8'h00);
            pipe.rec.sf = aln[7];
            pipe.rec.pf = aru_pkg::parity(aln);
         end
         aru_pkg::OP_CBW: begin
            pipe.rec.ax = {{8{al[7]}}, al};
            pipe.rec.cf = req.cin;
            pipe.rec.af = req.ain;
         end
         aru_pkg::OP_CWD: begin
            pipe.rec.dx = {16{req.ax[15]}};
            pipe.rec.cf = req.cin;
            pipe.rec.af = req.ain;
         end
         aru_pkg::OP_MUL, aru_pkg::OP_IMUL, aru_pkg::OP_DIV, aru_pkg::OP_IDIV: ;
         default: begin
            pipe.rec.cf = req.cin;
            pipe.rec.af = req.ain;
         end
      endcase
      if (req.opcode <= aru_pkg::OP_NEG) begin
         pipe.rec.res = ar;
         pipe.rec.wb  = (req.opcode != aru_pkg::OP_CMP);
      end else begin
         pipe.rec.res = pipe.rec.ax;
         pipe.rec.wb  = 1'b0;
      end
   end

   // Multiplier: both sizes share one 17x17 signed product.
   always_comb begin
      sgn = (req.opcode == aru_pkg::OP_IMUL);
      if (req.word_size) begin
         ma = {sgn & d[15], d};
         mb = {sgn & req.ax[15], req.ax};
      end else begin
         ma = {{9{sgn & d[7]}}, d[7:0]};
         mb = {{9{sgn & al[7]}}, al};
      end
      prod34 = $signed(ma) * $signed(mb);
      mprod  = prod34[31:0];
   end

   // Divider setup: magnitudes, and the early check that the quotient fits the operand size.
   always_comb begin
      dividend = req.word_size ? {req.dx, req.ax} : {16'h0000, req.ax};
      nd       = (req.opcode == aru_pkg::OP_IDIV) &
                 (req.word_size ? req.dx[15] : req.ax[15]);
      nv       = (req.opcode == aru_pkg::OP_IDIV) & (req.word_size ? d[15] : d[7]);
      negd     = 32'd0 - dividend;
      a        = nd ? (req.word_size ? negd : {16'h0000, negd[15:0]}) : dividend;
      bneg     = (req.word_size ? 17'h10000 : 17'h00100) - {1'b0, d};
      b        = nv ? bneg[15:0] : d;
      hi       = req.word_size ? a[31:16] : {8'h00, a[15:8]};
      dvs.rem  = req.word_size ? a[31:16] : 16'h0000;
      dvs.quo  = a[15:0];
      dvs.dvsr = b;
      dvs.nd   = nd;
      dvs.nv   = nv;
      dvs.err  = (b == 16'h0000) || (hi >= b);
   end

endmodule

### rtl/aru_div_stage.sv
module aru_div_stage (
   input  aru_pkg::pipe_type stage_in,
   output aru_pkg::pipe_type stage_out
);

   logic [16:0] t;
   logic [15:0] rem, quo;
   logic        qb;

   always_comb begin
      rem = stage_in.dv.rem;
      quo = stage_in.dv.quo;
      t   = '0;
      qb  = 1'b0;
      for (int i = 0; i < aru_pkg::BITS_PER_STAGE; i++) begin
         t = {rem, quo[15]};
         if (t >= {1'b0, stage_in.dv.dvsr}) begin
            t  = t - {1'b0, stage_in.dv.dvsr};
            qb = 1'b1;
         end else begin
            qb = 1'b0;
         end
         rem = t[15:0];
         quo = {quo[14:0], qb};
      end
      stage_out        = stage_in;
      stage_out.dv.rem = rem;
      stage_out.dv.quo = quo;
   end

endmodule

### rtl/aru_back.sv
module aru_back (
   input  aru_pkg::pipe_type pipe,
   output aru_pkg::rec_type  rec,
   output logic              div_err
);

   logic        ovf, sgn, neg, err;
   logic [15:0] lo, hi, limit, q, r;

   always_comb begin
      rec     = pipe.rec;
      div_err = 1'b0;
      lo      = pipe.prod[15:0];
      hi      = pipe.prod[31:16];
      sgn     = (pipe.opcode == aru_pkg::OP_IDIV);
      neg     = pipe.dv.nd ^ pipe.dv.nv;
      if (pipe.word_size) begin
         limit = neg ? 16'h8000 : 16'h7FFF;
      end else begin
         limit = neg ? 16'h0080 : 16'h007F;
      end
      err = pipe.dv.err || (sgn && (pipe.dv.quo > limit));
      q   = (sgn && neg) ? (16'h0000 - pipe.dv.quo) : pipe.dv.quo;
      r   = (sgn && pipe.dv.nd) ? (16'h0000 - pipe.dv.rem) : pipe.dv.rem;
      ovf = 1'b0;
      unique case (pipe.opcode)
         aru_pkg::OP_MUL, aru_pkg::OP_IMUL: begin
            if (pipe.word_size) begin
               ovf = (pipe.opcode == aru_pkg::OP_MUL) ? (hi != 16'h0000)
                                                       : (hi != {16{lo[15]}});
               rec.ax = lo;
               rec.dx = hi;
               rec.zf = (lo == 16'h0000);
               rec.sf = lo[15];
            end else begin
               ovf = (pipe.opcode == aru_pkg::OP_MUL) ? (lo[15:8] != 8'h00)
                                                       : (lo[15:8] != {8{lo[7]}});
               rec.ax = lo;
               rec.zf = (lo[7:0] == 8'h00);
               rec.sf = lo[7];
            end
            rec.pf  = aru_pkg::parity(lo[7:0]);
            rec.cf  = ovf;
            rec.of  = ovf;
            rec.af  = 1'b0;
            rec.res = rec.ax;
         end
         aru_pkg::OP_DIV, aru_pkg::OP_IDIV: begin
            if (!err) begin
               if (pipe.word_size) begin
                  rec.ax = q;
                  rec.dx = r;
               end else begin
                  rec.ax = {r[7:0], q[7:0]};
               end
            end
            div_err = err;
            rec.res = rec.ax;
         end
         default: ;
      endcase
   end

endmodule
